@@ rtl/core/tlvd_pkg.sv @@
// Package for the TLV message deframer core.
// Holds the phase and event codes, the result record and the reset limit.
// No dependencies.
package tlvd_pkg;

    localparam logic [15:0] MAX_FIELD_RESET = 16'd2048;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_PAYLOAD  = 2'd1,
        PH_REJECTED = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_EMPTY   = 2'd1,
        EV_REJECT  = 2'd2
    } event_t;

    typedef struct packed {
        event_t      evt;
        logic [15:0] id;
        logic [7:0]  data;
        logic        last;
    } result_t;

endpackage

@@ rtl/core/tlvd_input_stage.sv @@
// Input register of the TLV deframer: holds one accepted byte request.
// Depends on tlvd_pkg.
module tlvd_input_stage
    import tlvd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
        end
    end

endmodule

@@ rtl/core/tlvd_parser.sv @@
// Framing state of the TLV deframer: header collection, limit check,
// payload countdown and the limit register. Depends on tlvd_pkg.
module tlvd_parser
    import tlvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        held_valid,
    input  logic [7:0]  held_byte,
    input  logic        advance,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [23:0] shift_reg;
    logic [23:0] shift_next;
    logic [15:0] id_reg;
    logic [15:0] id_next;
    logic [15:0] remain_reg;
    logic [15:0] remain_next;
    logic [15:0] max_reg;
    logic [15:0] hdr_id;
    logic [15:0] hdr_len;
    logic        hdr_bad;
    logic        pay_last;

    assign hdr_id   = shift_reg[23:8];
    assign hdr_len  = {shift_reg[7:0], held_byte};
    assign hdr_bad  = (hdr_id > max_reg) || (hdr_len > max_reg);
    assign pay_last = (remain_reg <= 16'd1);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        shift_next  = shift_reg;
        id_next     = id_reg;
        remain_next = remain_reg;
        res_valid   = 1'b0;
        res.evt     = EV_PAYLOAD;
        res.id      = id_reg;
        res.data    = 8'd0;
        res.last    = 1'b0;
        case (phase_reg)
            PH_HEADER:
            begin
                if (count_reg != 2'd3)
                begin
                    shift_next = {shift_reg[15:0], held_byte};
                    count_next = count_reg + 2'd1;
                end
                else
                begin
                    count_next = 2'd0;
                    shift_next = 24'd0;
                    res.id     = hdr_id;
                    res.last   = 1'b1;
                    if (hdr_bad)
                    begin
                        phase_next = PH_REJECTED;
                        res_valid  = held_valid;
                        res.evt    = EV_REJECT;
                    end
                    else if (hdr_len == 16'd0)
                    begin
                        id_next     = hdr_id;
                        remain_next = 16'd0;
                        res_valid   = held_valid;
                        res.evt     = EV_EMPTY;
                    end
                    else
                    begin
                        id_next     = hdr_id;
                        remain_next = hdr_len;
                        phase_next  = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res_valid = held_valid;
                res.evt   = EV_PAYLOAD;
                res.data  = held_byte;
                res.last  = pay_last;
                if (pay_last)
                begin
                    remain_next = 16'd0;
                    phase_next  = PH_HEADER;
                    count_next  = 2'd0;
                    shift_next  = 24'd0;
                end
                else
                begin
                    remain_next = remain_reg - 16'd1;
                end
            end
            default:
            begin
                // drop the byte
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            count_reg  <= 2'd0;
            shift_reg  <= 24'd0;
            id_reg     <= 16'd0;
            remain_reg <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            shift_reg  <= shift_next;
            id_reg     <= id_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_FIELD_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_reg <= cfg_wr_data;
        end
    end

endmodule

@@ rtl/core/tlvd_output_stage.sv @@
// Result register of the TLV deframer: holds one result request until taken.
// Depends on tlvd_pkg for the result record.
module tlvd_output_stage
    import tlvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t held_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign held_res  = res_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

@@ rtl/core/tlv_message_deframer_core.sv @@
// TLV message deframer, top level.
// Instantiates tlvd_input_stage, tlvd_parser and tlvd_output_stage; uses tlvd_pkg.
//
// Input channel: one stream byte per request on data_byte, in_valid/in_stall.
// Output channel: event_res, message_id, payload_byte, last_of_message,
// out_valid/out_stall. Header: 16-bit big-endian id, then 16-bit length.
// Events: 0 payload byte, 1 empty message, 2 header rejected (id or length
// above the limit); after a rejection every later byte is dropped.
// Configuration: cfg_wr_en writes cfg_wr_data into the limit register.
// A byte accepted into the input register has its result, if any, loaded
// into the result register once the result register is free. Throughput:
// one byte per cycle while the receiver does not stall. The first three
// header bytes and the fourth byte of an accepted non-empty header give no result.
// Reset: framing restarts at the header, the limit returns to 2048, both
// channels go empty. When the receiver stalls, the result holds; one more
// byte is taken into the input register, and bytes that give no result
// keep moving through.
module tlv_message_deframer_core
    import tlvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [15:0] message_id,
    output logic [7:0]  payload_byte,
    output logic        last_of_message
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       advance;
    logic       res_valid;
    logic       out_free;
    result_t    res;
    result_t    out_res;

    assign advance = held_valid && (out_free || !res_valid);

    tlvd_input_stage u_input
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    tlvd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .held_valid  (held_valid),
        .held_byte   (held_byte),
        .advance     (advance),
        .res_valid   (res_valid),
        .res         (res)
    );

    tlvd_output_stage u_output
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .held_res  (out_res)
    );

    assign event_res       = out_res.evt;
    assign message_id      = out_res.id;
    assign payload_byte    = out_res.data;
    assign last_of_message = out_res.last;

endmodule
